FILE: hw/rtl/vrt_pkg.sv
// Shared constants and types for the voxel ray traversal block.
package vrt_pkg;
  localparam int COORD_INT_BITS  = 16;
  localparam int COORD_FRAC_BITS = 8;
  localparam int DIR_FRAC_BITS   = 14;
  localparam int COORD_W   = COORD_INT_BITS + COORD_FRAC_BITS;
  localparam int DIR_W     = 2 + DIR_FRAC_BITS;
  localparam int VOX_W     = COORD_INT_BITS;
  localparam int DIST_FRAC = 16;
  localparam int DIST_W    = 32;
  localparam int LIM_W     = 16;
  localparam int LIM_FRAC  = 8;
  localparam int TYPE_W    = 8;
  localparam int HP_SHIFT  = DIR_FRAC_BITS + DIST_FRAC - COORD_FRAC_BITS;
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int SQRT_STEPS = DIV_W / 2;
  localparam int IN_W  = 3 * COORD_W + 3 * DIR_W + LIM_W + TYPE_W;
  localparam int OUT_RAW_W = 3 * VOX_W + 3 + LIM_W + TYPE_W + 3 * COORD_W;
  localparam int OUT_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [1:0] KIND_PROBE = 2'd0;
  localparam logic [1:0] KIND_HIT   = 2'd1;
  localparam logic [1:0] KIND_MISS  = 2'd2;
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;
endpackage

FILE: hw/rtl/vrt_divider.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
module vrt_divider (
  input  logic              clk,
  input  logic              rst,
  input  vrt_pkg::div_req_t req,
  output vrt_pkg::div_rsp_t rsp
);
  import vrt_pkg::*;

  logic [DIV_W:0]     rem;
  logic [DIV_W-1:0]   quo;
  logic [DIV_W-1:0]   den;
  logic [DIV_CNT_W-1:0] cnt;
  logic               busy;
  logic               done;
  logic [DIV_W:0]     shifted;
  logic [DIV_W+1:0]   diff;

  assign shifted = {rem[DIV_W-1:0], quo[DIV_W-1]};
  assign diff = {1'b0, shifted} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= '0;
        rem <= '0;
        quo <= req.num;
        den <= req.den;
      end else if (busy) begin
        if (!diff[DIV_W+1]) begin
          rem <= diff[DIV_W:0];
          quo <= {quo[DIV_W-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo = quo;
endmodule

FILE: hw/rtl/voxel_ray_traversal.sv
// Top level of the voxel ray traversal block: ray setup sequencer and voxel walker.
// The block walks a ray through a voxel grid. A transaction on the s_ side with
// s_tuser 0 starts a ray; with s_tuser 1 it answers the last probe with a block type.
// Every accepted transaction except an answer with no active ray yields exactly one
// m_ side transaction: a probe request, a hit or a miss (m_tuser gives the kind).
// Ray setup from acceptance to the result goes through these steps: squaring of each
// direction component in turn on one multiplier, a bit-by-bit square root, then per
// axis a division for the unit component and one for the reciprocal on the shared
// divider, plus a multiply for the side distance. An axis with a zero unit component
// takes only its first division, and a zero direction gives its result at the end of
// the square root. An answer of air takes a compare and add: its result is presented
// in the cycle after acceptance. A hit result is computed one axis of the hit point
// per cycle on the multiplier.
// The block takes one transaction at a time: s_tready is low while work is under
// way and while a result waits in the output register. If the receiver stalls,
// the result stays on m_tdata and no new transaction is accepted.
// Reset clears the ray state; the first transaction after reset may be taken at once.
module voxel_ray_traversal (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_distance, block_type
  input  logic [vrt_pkg::IN_W-1:0]  s_tdata,
  // mode
  input  logic                      s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // voxel_x, voxel_y, voxel_z, normal_axis, normal_negative, travel_distance,
  // hit_type, hit_point_x, hit_point_y, hit_point_z, zero fill
  output logic [vrt_pkg::OUT_W-1:0] m_tdata,
  // result_kind
  output logic [1:0]                m_tuser
);
  import vrt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQ   = 7'b0000010,
    S_SQRT = 7'b0000100,
    S_UDIV = 7'b0001000,
    S_RDIV = 7'b0010000,
    S_SIDE = 7'b0100000,
    S_HIT  = 7'b1000000
  } state_t;

  state_t state;
  logic [1:0] ax;
  logic [4:0] sq_cnt;

  logic signed [COORD_W-1:0] ray_origin [3];
  logic [DIR_W-1:0]          dmag [3];
  logic                      dneg [3];
  logic signed [DIR_W-1:0]   unit_dir [3];
  logic [VOX_W-1:0]          cur_voxel [3];
  logic [DIST_W-1:0]         side_dist [3];
  logic [DIST_W-1:0]         delta_dist [3];
  logic                      step_positive [3];
  logic [1:0]                last_axis;
  logic [DIST_W-1:0]         walked_distance;
  logic [LIM_W-1:0]          limit_distance;
  logic                      ray_active;
  logic [TYPE_W-1:0]         hit_blk;
  logic signed [COORD_W-1:0] hp [3];

  logic [DIV_W-1:0] sq_v, sq_r, sq_b;
  logic [DIV_W:0]   sq_t;

  logic     div_start;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [1:0]        o_kind;
  logic [VOX_W-1:0]  o_vox [3];
  logic [1:0]        o_axis;
  logic              o_neg;
  logic [LIM_W-1:0]  o_dist;
  logic [TYPE_W-1:0] o_type;
  logic [COORD_W-1:0] o_hp [3];

  logic              accept;
  logic              mode;
  logic [TYPE_W-1:0] in_type;
  logic [1:0]        a_sel;
  logic [DIST_W:0]   side_sum;
  logic [DIST_W-1:0] walk_new;
  logic [DIST_W-1:0] lim_full;
  logic [2*DIR_W-1:0] sq_prod;
  logic [DIR_W-1:0]  uq;
  logic [COORD_FRAC_BITS:0] off;
  logic [COORD_FRAC_BITS+DIST_W:0] side_prod;
  logic signed [DIR_W+DIST_W:0] hp_prod;
  logic signed [COORD_W-1:0] hp_new;
  logic [COORD_FRAC_BITS-1:0] frac;

  vrt_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign accept = s_tvalid && s_tready;
  assign mode = s_tuser;
  assign in_type = s_tdata[IN_W-1 -: TYPE_W];

  always_comb begin
    if (side_dist[0] < side_dist[1] && side_dist[0] < side_dist[2]) begin
      a_sel = AXIS_X;
    end else if (side_dist[1] < side_dist[2]) begin
      a_sel = AXIS_Y;
    end else begin
      a_sel = AXIS_Z;
    end
  end

  assign side_sum = {1'b0, side_dist[a_sel]} + {1'b0, delta_dist[a_sel]};
  assign walk_new = side_dist[a_sel];
  assign lim_full = DIST_W'({limit_distance, {(DIST_FRAC - LIM_FRAC){1'b0}}});
  assign sq_prod = dmag[ax] * dmag[ax];
  assign sq_t = {1'b0, sq_r} + {1'b0, sq_b};
  assign uq = div_rsp.quo[DIR_W-1:0];
  assign frac = ray_origin[ax][COORD_FRAC_BITS-1:0];
  assign off = unit_dir[ax][DIR_W-1] ? {1'b0, frac}
                                     : (COORD_FRAC_BITS+1)'(1 << COORD_FRAC_BITS) - {1'b0, frac};
  assign side_prod = off * delta_dist[ax];
  assign hp_prod = unit_dir[ax] * $signed({1'b0, walked_distance});
  assign hp_new = ray_origin[ax] + COORD_W'(hp_prod >>> HP_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ax <= AXIS_X;
      sq_cnt <= '0;
      m_tvalid <= 1'b0;
      div_start <= 1'b0;
      ray_active <= 1'b0;
      last_axis <= AXIS_X;
      walked_distance <= '0;
      limit_distance <= '0;
      for (int i = 0; i < 3; i++) begin
        cur_voxel[i] <= '0;
        side_dist[i] <= '0;
        delta_dist[i] <= '0;
        step_positive[i] <= 1'b0;
        unit_dir[i] <= '0;
        ray_origin[i] <= '0;
      end
    end else begin
      div_start <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && !mode) begin
            for (int i = 0; i < 3; i++) begin
              ray_origin[i] <= s_tdata[i*COORD_W +: COORD_W];
              dneg[i] <= s_tdata[3*COORD_W + i*DIR_W + DIR_W - 1];
              dmag[i] <= s_tdata[3*COORD_W + i*DIR_W + DIR_W - 1]
                         ? DIR_W'(-s_tdata[3*COORD_W + i*DIR_W +: DIR_W])
                         : s_tdata[3*COORD_W + i*DIR_W +: DIR_W];
              cur_voxel[i] <= s_tdata[i*COORD_W + COORD_FRAC_BITS +: VOX_W];
            end
            limit_distance <= s_tdata[3*COORD_W + 3*DIR_W +: LIM_W];
            last_axis <= AXIS_X;
            walked_distance <= '0;
            ray_active <= 1'b1;
            sq_v <= '0;
            ax <= AXIS_X;
            state <= S_SQ;
          end else if (accept && ray_active) begin
            if (in_type != '0) begin
              hit_blk <= in_type;
              ray_active <= 1'b0;
              ax <= AXIS_X;
              state <= S_HIT;
            end else begin
              walked_distance <= walk_new;
              side_dist[a_sel] <= side_sum[DIST_W] ? '1 : side_sum[DIST_W-1:0];
              cur_voxel[a_sel] <= step_positive[a_sel] ? cur_voxel[a_sel] + 1'b1
                                                       : cur_voxel[a_sel] - 1'b1;
              last_axis <= a_sel;
              m_tvalid <= 1'b1;
              o_axis <= '0;
              o_neg <= 1'b0;
              o_type <= '0;
              for (int i = 0; i < 3; i++) begin
                o_hp[i] <= '0;
              end
              if (walk_new >= lim_full) begin
                ray_active <= 1'b0;
                o_kind <= KIND_MISS;
                o_dist <= limit_distance;
                for (int i = 0; i < 3; i++) begin
                  o_vox[i] <= '0;
                end
              end else begin
                o_kind <= KIND_PROBE;
                o_dist <= '0;
                for (int i = 0; i < 3; i++) begin
                  o_vox[i] <= (i == int'(a_sel))
                              ? (step_positive[i] ? cur_voxel[i] + 1'b1 : cur_voxel[i] - 1'b1)
                              : cur_voxel[i];
                end
              end
            end
          end
        end
        S_SQ: begin
          sq_v <= sq_v + DIV_W'(sq_prod);
          if (ax == AXIS_Z) begin
            sq_r <= '0;
            sq_b <= DIV_W'(1) << (DIV_W - 2);
            sq_cnt <= '0;
            state <= S_SQRT;
          end else begin
            ax <= ax + 1'b1;
          end
        end
        S_SQRT: begin
          if ({1'b0, sq_v} >= sq_t) begin
            sq_v <= sq_v - sq_t[DIV_W-1:0];
            sq_r <= (sq_r >> 1) + sq_b;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_b <= sq_b >> 2;
          sq_cnt <= sq_cnt + 1'b1;
          if (sq_cnt == 5'(SQRT_STEPS - 1)) begin
            ax <= AXIS_X;
            if (sq_r == '0 && !({1'b0, sq_v} >= sq_t)) begin
              for (int i = 0; i < 3; i++) begin
                unit_dir[i] <= '0;
                step_positive[i] <= 1'b0;
                delta_dist[i] <= '1;
                side_dist[i] <= '1;
              end
              m_tvalid <= 1'b1;
              o_axis <= '0;
              o_neg <= 1'b0;
              o_type <= '0;
              for (int i = 0; i < 3; i++) begin
                o_hp[i] <= '0;
                o_vox[i] <= (limit_distance == '0) ? '0 : cur_voxel[i];
              end
              o_kind <= (limit_distance == '0) ? KIND_MISS : KIND_PROBE;
              o_dist <= (limit_distance == '0) ? limit_distance : '0;
              ray_active <= (limit_distance != '0);
              state <= S_IDLE;
            end else begin
              div_start <= 1'b1;
              state <= S_UDIV;
            end
          end
        end
        S_UDIV: begin
          if (div_rsp.done) begin
            unit_dir[ax] <= dneg[ax] ? DIR_W'(-uq) : uq;
            step_positive[ax] <= !dneg[ax] && (uq != '0);
            if (uq == '0) begin
              delta_dist[ax] <= '1;
              side_dist[ax] <= '1;
              if (ax == AXIS_Z) begin
                m_tvalid <= 1'b1;
                o_axis <= '0;
                o_neg <= 1'b0;
                o_type <= '0;
                for (int i = 0; i < 3; i++) begin
                  o_hp[i] <= '0;
                  o_vox[i] <= (limit_distance == '0) ? '0 : cur_voxel[i];
                end
                o_kind <= (limit_distance == '0) ? KIND_MISS : KIND_PROBE;
                o_dist <= (limit_distance == '0) ? limit_distance : '0;
                ray_active <= (limit_distance != '0);
                state <= S_IDLE;
              end else begin
                ax <= ax + 1'b1;
                div_start <= 1'b1;
              end
            end else begin
              div_start <= 1'b1;
              state <= S_RDIV;
            end
          end
        end
        S_RDIV: begin
          if (div_rsp.done) begin
            delta_dist[ax] <= div_rsp.quo;
            state <= S_SIDE;
          end
        end
        S_SIDE: begin
          side_dist[ax] <= side_prod[COORD_FRAC_BITS+DIST_W] ? '1
                           : side_prod[COORD_FRAC_BITS +: DIST_W];
          if (ax == AXIS_Z) begin
            m_tvalid <= 1'b1;
            o_axis <= '0;
            o_neg <= 1'b0;
            o_type <= '0;
            for (int i = 0; i < 3; i++) begin
              o_hp[i] <= '0;
              o_vox[i] <= (limit_distance == '0) ? '0 : cur_voxel[i];
            end
            o_kind <= (limit_distance == '0) ? KIND_MISS : KIND_PROBE;
            o_dist <= (limit_distance == '0) ? limit_distance : '0;
            ray_active <= (limit_distance != '0);
            state <= S_IDLE;
          end else begin
            ax <= ax + 1'b1;
            div_start <= 1'b1;
            state <= S_UDIV;
          end
        end
        S_HIT: begin
          hp[ax] <= hp_new;
          if (ax == AXIS_Z) begin
            m_tvalid <= 1'b1;
            o_kind <= KIND_HIT;
            o_axis <= last_axis;
            o_neg <= step_positive[last_axis];
            o_dist <= walked_distance[DIST_FRAC - LIM_FRAC +: LIM_W];
            o_type <= hit_blk;
            for (int i = 0; i < 3; i++) begin
              o_vox[i] <= cur_voxel[i];
            end
            o_hp[0] <= hp[0];
            o_hp[1] <= hp[1];
            o_hp[2] <= hp_new;
            state <= S_IDLE;
          end else begin
            ax <= ax + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    div_req.start = div_start;
    div_req.num = (state == S_RDIV) ? DIV_W'(1) << (DIST_FRAC + DIR_FRAC_BITS)
                : (DIV_W'(dmag[ax]) << DIR_FRAC_BITS) + (sq_r >> 1);
    div_req.den = (state == S_RDIV) ? DIV_W'(unit_dir[ax][DIR_W-1] ? -unit_dir[ax]
                                                                   : unit_dir[ax])
                : sq_r;
  end

  assign m_tuser = o_kind;
  assign m_tdata = OUT_W'({o_hp[2], o_hp[1], o_hp[0], o_type, o_dist, o_neg, o_axis,
                           o_vox[2], o_vox[1], o_vox[0]});

`ifndef ASSERT_OFF
  a_ready_no_pending: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("input ready while a result is pending");
  a_orphan_answer: assert property (@(posedge clk) disable iff (rst)
    (accept && mode && !ray_active) |=> !m_tvalid)
    else $error("answer without an active ray produced a result");
  a_miss_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_kind == KIND_MISS) |-> (o_type == '0 && !ray_active))
    else $error("miss result with hit type or live ray");
  a_hit_ends_ray: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_kind == KIND_HIT) |-> !ray_active)
    else $error("hit result with live ray");
`endif
endmodule
